### design/lpdq_pkg.sv
// Package for the link port delay queues: widths, codes and the command
// structs shared between controller, datapath and queues. No dependencies.
package lpdq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam int TAG_W       = 16;
   localparam int SIZE_W      = 16;
   localparam int BASE_W      = 8;
   localparam int CD_W        = 10;
   localparam int STATUS_W    = 2;
   localparam int OUT_COUNT_W = 5;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 8;

   // size / 100 as (size * 5243) >> 19, exact for sizes up to 43698
   localparam int             RECIP_W   = 13;
   localparam logic [RECIP_W-1:0] DIV_RECIP = 13'd5243;
   localparam int             DIV_SHIFT = 19;
   localparam int             PROD_W    = SIZE_W + RECIP_W;

   localparam logic [BASE_W-1:0] RESET_BASE_DELAY = 8'd3;

   localparam logic DEST_LOCAL  = 1'b0;
   localparam logic DEST_REMOTE = 1'b1;

   typedef enum logic [1:0] {
      REQ_PUSH_IN  = 2'd0,
      REQ_PUSH_OUT = 2'd1,
      REQ_TICK     = 2'd2,
      REQ_POP_IN   = 2'd3
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK            = 2'd0,
      STAT_FULL          = 2'd1,
      STAT_NONE_READY    = 2'd2,
      STAT_NOT_CONNECTED = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IN_BASE   = 2'd0,
      CSR_OUT_BASE  = 2'd1,
      CSR_CONNECTED = 2'd2
   } csr_index_type;

   typedef enum logic {
      ST_IDLE,
      ST_APPLY
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic apply;
   } dp_cmd_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic tick;
   } q_cmd_type;

endpackage

### design/lpdq_req_if.sv
// Request channel: one word per push, tick or pop.
// Depends on lpdq_pkg.
interface lpdq_req_if;
   import lpdq_pkg::*;
   logic              valid;
   logic              ready;
   logic [1:0]        req_type;
   logic [TAG_W-1:0]  msg_tag;
   logic [SIZE_W-1:0] msg_size;

   modport source (output valid, req_type, msg_tag, msg_size, input ready);
   modport sink   (input valid, req_type, msg_tag, msg_size, output ready);
endinterface

### design/lpdq_rsp_if.sv
// Response channel: one word per request.
// Depends on lpdq_pkg.
interface lpdq_rsp_if;
   import lpdq_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [STATUS_W-1:0]    status;
   logic                   out_valid;
   logic                   out_dest;
   logic [TAG_W-1:0]       out_tag;
   logic [SIZE_W-1:0]      out_size;
   logic                   incoming_ready;
   logic [OUT_COUNT_W-1:0] outgoing_count;

   modport source (output valid, status, out_valid, out_dest, out_tag, out_size,
                   incoming_ready, outgoing_count, input ready);
   modport sink   (input valid, status, out_valid, out_dest, out_tag, out_size,
                   incoming_ready, outgoing_count, output ready);
endinterface

### design/lpdq_csr_if.sv
// Configuration write channel: register index and write data.
// Depends on lpdq_pkg.
interface lpdq_csr_if;
   import lpdq_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### design/lpdq_queue.sv
// One FIFO of message entries with a per-entry countdown; all countdowns
// decrement in parallel on a tick. Depends on lpdq_pkg.
module lpdq_queue
   import lpdq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  q_cmd_type         cmd,
   input  logic [TAG_W-1:0]  push_tag,
   input  logic [SIZE_W-1:0] push_size,
   input  logic [CD_W-1:0]   push_cd,
   output logic [TAG_W-1:0]  head_tag,
   output logic [SIZE_W-1:0] head_size,
   output logic              head_due,
   output logic              full,
   output logic [CNT_W-1:0]  count_after,
   output logic              due_after
);

   localparam int SUM_W = CNT_W + 1;

   logic [TAG_W-1:0]  tag_ff  [QUEUE_DEPTH];
   logic [SIZE_W-1:0] size_ff [QUEUE_DEPTH];
   logic [CD_W-1:0]   cd_ff   [QUEUE_DEPTH];
   logic [CD_W-1:0]   cd_in   [QUEUE_DEPTH];
   logic [PTR_W-1:0]  head_ff, head_in, next_head, tail;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SUM_W-1:0]  tail_sum;
   logic              do_push;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign do_push   = cmd.push && !full;
   assign tail_sum  = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign tail      = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                      PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(tail_sum);
   assign next_head = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;

   assign head_tag  = tag_ff[head_ff];
   assign head_size = size_ff[head_ff];
   assign head_due  = (count_ff != '0) && (cd_ff[head_ff] == '0);

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         cd_in[i] = cd_ff[i];
         if (cmd.tick && cd_ff[i] != '0) begin
            cd_in[i] = cd_ff[i] - 1'b1;
         end
      end
      if (do_push) begin
         cd_in[tail] = push_cd;
         count_in    = count_ff + 1'b1;
      end
      if (cmd.pop) begin
         head_in  = next_head;
         count_in = count_ff - 1'b1;
      end
   end

   assign count_after = count_in;
   assign due_after   = (count_in != '0) && (cd_in[head_in] == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         cd_ff[i] <= cd_in[i];
      end
      if (do_push) begin
         tag_ff[tail]  <= push_tag;
         size_ff[tail] <= push_size;
      end
   end

endmodule

### design/lpdq_ctrl.sv
// Controller: accepts a request word, waits for a free response slot,
// then commands the datapath to apply it. Depends on lpdq_pkg.
module lpdq_ctrl
   import lpdq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output dp_cmd_type cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (slot_free) begin
               cmd.apply    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_apply_needs_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |-> (!rsp_valid_ff || rsp_ready))
      else $error("apply while response slot occupied");

   a_load_then_apply: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == ST_APPLY))
      else $error("accepted word not followed by apply state");

   a_rsp_from_apply: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.apply))
      else $error("response raised without an applied request");

   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY) |-> !req_ready)
      else $error("request accepted while a request is pending");

endmodule

### design/lpdq_datapath.sv
// Datapath: config registers, request latch with size/100 multiply,
// both delay queues and the response register. Depends on lpdq_pkg, lpdq_queue.
module lpdq_datapath
   import lpdq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  dp_cmd_type             cmd,
   input  logic                   csr_write,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic [1:0]             req_type,
   input  logic [TAG_W-1:0]       msg_tag,
   input  logic [SIZE_W-1:0]      msg_size,
   output logic [STATUS_W-1:0]    status,
   output logic                   out_valid,
   output logic                   out_dest,
   output logic [TAG_W-1:0]       out_tag,
   output logic [SIZE_W-1:0]      out_size,
   output logic                   incoming_ready,
   output logic [OUT_COUNT_W-1:0] outgoing_count
);

   logic [BASE_W-1:0] in_base_ff, out_base_ff;
   logic              connected_ff;

   req_kind_type      op_ff;
   logic [TAG_W-1:0]  tag_ff;
   logic [SIZE_W-1:0] size_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [CD_W-1:0]   quot, in_cd, out_cd;

   q_cmd_type         in_cmd, out_cmd;
   logic [TAG_W-1:0]  in_head_tag, out_head_tag;
   logic [SIZE_W-1:0] in_head_size, out_head_size;
   logic              in_head_due, out_head_due, in_full, out_full;
   logic              in_due_after, out_due_after;
   logic [CNT_W-1:0]  in_count_after, out_count_after;

   status_type        status_in;
   logic              valid_in, dest_in;
   logic [TAG_W-1:0]  tag_in;
   logic [SIZE_W-1:0] size_in;

   logic [STATUS_W-1:0]    status_ff;
   logic                   out_valid_ff, out_dest_ff, incoming_ready_ff;
   logic [TAG_W-1:0]       out_tag_ff;
   logic [SIZE_W-1:0]      out_size_ff;
   logic [OUT_COUNT_W-1:0] outgoing_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_base_ff   <= RESET_BASE_DELAY;
         out_base_ff  <= RESET_BASE_DELAY;
         connected_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_IN_BASE:   in_base_ff   <= BASE_W'(csr_data);
            CSR_OUT_BASE:  out_base_ff  <= BASE_W'(csr_data);
            CSR_CONNECTED: connected_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_kind_type'(req_type);
         tag_ff  <= msg_tag;
         size_ff <= msg_size;
         prod_ff <= PROD_W'(msg_size) * PROD_W'(DIV_RECIP);
      end
   end

   assign quot   = prod_ff[DIV_SHIFT +: CD_W];
   assign in_cd  = CD_W'(in_base_ff) + quot;
   assign out_cd = CD_W'(out_base_ff) + quot;

   always_comb begin
      in_cmd    = '0;
      out_cmd   = '0;
      status_in = STAT_OK;
      valid_in  = 1'b0;
      dest_in   = DEST_LOCAL;
      tag_in    = '0;
      size_in   = '0;
      if (cmd.apply) begin
         unique case (op_ff)
            REQ_PUSH_IN: begin
               in_cmd.push = 1'b1;
               if (in_full) status_in = STAT_FULL;
            end
            REQ_PUSH_OUT: begin
               out_cmd.push = 1'b1;
               if (out_full) status_in = STAT_FULL;
            end
            REQ_TICK: begin
               in_cmd.tick  = 1'b1;
               out_cmd.tick = 1'b1;
               if (out_head_due) begin
                  if (connected_ff) begin
                     out_cmd.pop = 1'b1;
                     valid_in    = 1'b1;
                     dest_in     = DEST_REMOTE;
                     tag_in      = out_head_tag;
                     size_in     = out_head_size;
                  end else begin
                     status_in = STAT_NOT_CONNECTED;
                  end
               end
            end
            REQ_POP_IN: begin
               if (in_head_due) begin
                  in_cmd.pop = 1'b1;
                  valid_in   = 1'b1;
                  dest_in    = DEST_LOCAL;
                  tag_in     = in_head_tag;
                  size_in    = in_head_size;
               end else begin
                  status_in = STAT_NONE_READY;
               end
            end
            default: ;
         endcase
      end
   end

   lpdq_queue u_in_queue (
      .clock       (clock),
      .reset       (reset),
      .cmd         (in_cmd),
      .push_tag    (tag_ff),
      .push_size   (size_ff),
      .push_cd     (in_cd),
      .head_tag    (in_head_tag),
      .head_size   (in_head_size),
      .head_due    (in_head_due),
      .full        (in_full),
      .count_after (in_count_after),
      .due_after   (in_due_after)
   );

   lpdq_queue u_out_queue (
      .clock       (clock),
      .reset       (reset),
      .cmd         (out_cmd),
      .push_tag    (tag_ff),
      .push_size   (size_ff),
      .push_cd     (out_cd),
      .head_tag    (out_head_tag),
      .head_size   (out_head_size),
      .head_due    (out_head_due),
      .full        (out_full),
      .count_after (out_count_after),
      .due_after   (out_due_after)
   );

   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         status_ff         <= status_in;
         out_valid_ff      <= valid_in;
         out_dest_ff       <= dest_in;
         out_tag_ff        <= tag_in;
         out_size_ff       <= size_in;
         incoming_ready_ff <= in_due_after;
         outgoing_count_ff <= OUT_COUNT_W'(out_count_after);
      end
   end

   assign status         = status_ff;
   assign out_valid      = out_valid_ff;
   assign out_dest       = out_dest_ff;
   assign out_tag        = out_tag_ff;
   assign out_size       = out_size_ff;
   assign incoming_ready = incoming_ready_ff;
   assign outgoing_count = outgoing_count_ff;

   a_in_count_bound: assert property (@(posedge clock) disable iff (reset)
      in_count_after <= CNT_W'(QUEUE_DEPTH))
      else $error("incoming queue count beyond depth");

   a_out_due_held: assert property (@(posedge clock) disable iff (reset)
      out_due_after |-> (out_count_after != '0))
      else $error("outgoing head due while queue empty");

   a_leave_is_ok: assert property (@(posedge clock) disable iff (reset)
      (cmd.apply && valid_in) |-> (status_in == STAT_OK))
      else $error("leaving word with non-ok status");

endmodule

### design/link_port_delay_queues.sv
// Link port with incoming and outgoing delay queues of message handles.
// Depends on lpdq_pkg, the three channel interfaces, lpdq_ctrl, lpdq_datapath.
//
// Channels: req_port carries one word per operation (push incoming, push
// outgoing, tick, pop incoming) with tag and byte size; rsp_port returns
// exactly one word per request with status, the leaving message if any,
// the incoming-ready flag and the outgoing fill after the operation.
// csr_port writes incoming base delay, outgoing base delay and the remote
// connected flag; it is always ready. The user must write it only while
// idle; the block itself does not enforce this. Each pushed entry counts
// down base delay + size/100 ticks. A new request is accepted only once
// the previous one is applied: the load step registers the size/100
// reciprocal multiply, the apply step updates the queues and loads the
// response register. Countdowns of all entries drop in parallel.
// Reset: both queues empty, base delays 3, remote disconnected, no response.
// Stall: while a response waits, one more request is accepted and held in
// the apply stage until the response register frees up.
module link_port_delay_queues
   import lpdq_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   lpdq_req_if.sink   req_port,
   lpdq_rsp_if.source rsp_port,
   lpdq_csr_if.sink   csr_port
);

   dp_cmd_type cmd;

   assign csr_port.ready = 1'b1;

   lpdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready),
      .cmd       (cmd)
   );

   lpdq_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .csr_write      (csr_port.valid),
      .csr_index      (csr_port.index),
      .csr_data       (csr_port.data),
      .req_type       (req_port.req_type),
      .msg_tag        (req_port.msg_tag),
      .msg_size       (req_port.msg_size),
      .status         (rsp_port.status),
      .out_valid      (rsp_port.out_valid),
      .out_dest       (rsp_port.out_dest),
      .out_tag        (rsp_port.out_tag),
      .out_size       (rsp_port.out_size),
      .incoming_ready (rsp_port.incoming_ready),
      .outgoing_count (rsp_port.outgoing_count)
   );

endmodule

### tb/lpdq_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the link port delay queues: predicts the response word of
// every accepted request word and checks the returned words in order.
// Depends on lpdq_pkg.
package lpdq_tb_pkg;
   import lpdq_pkg::*;

   localparam int Q_IN           = 0;
   localparam int Q_OUT          = 1;
   localparam int BYTES_PER_TICK = 100;
   localparam int REPORT_CAP     = 40;

   typedef struct packed {
      req_kind_type      kind;
      logic [TAG_W-1:0]  tag;
      logic [SIZE_W-1:0] size;
   } req_word_type;

   typedef struct packed {
      status_type             status;
      logic                   out_valid;
      logic                   out_dest;
      logic [TAG_W-1:0]       out_tag;
      logic [SIZE_W-1:0]      out_size;
      logic                   incoming_ready;
      logic [OUT_COUNT_W-1:0] outgoing_count;
   } rsp_word_type;

   class delay_queue_scoreboard;
      logic [TAG_W-1:0]  tags  [2][QUEUE_DEPTH];
      logic [SIZE_W-1:0] sizes [2][QUEUE_DEPTH];
      logic [CD_W-1:0]   cds   [2][QUEUE_DEPTH];
      int                head  [2];
      int                count [2];
      logic [BASE_W-1:0] base_delay [2];
      logic              connected;
      rsp_word_type      expected_rsps [$];
      int mismatches, words_in, words_out, drops, sends, pops, held_sends;

      function new();
         head       = '{0, 0};
         count      = '{0, 0};
         base_delay = '{RESET_BASE_DELAY, RESET_BASE_DELAY};
         connected  = 1'b0;
         mismatches = 0;
         words_in   = 0;
         words_out  = 0;
         drops      = 0;
         sends      = 0;
         pops       = 0;
         held_sends = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_IN_BASE:   base_delay[Q_IN]  = data;
            CSR_OUT_BASE:  base_delay[Q_OUT] = data;
            CSR_CONNECTED: connected         = data[0];
            default: ;
         endcase
      endfunction

      function bit head_due(int q);
         return count[q] != 0 && cds[q][head[q]] == '0;
      endfunction

      function bit push_entry(int q, req_word_type w);
         int slot;
         if (count[q] >= QUEUE_DEPTH) return 1'b0;
         slot = (head[q] + count[q]) % QUEUE_DEPTH;
         tags[q][slot]  = w.tag;
         sizes[q][slot] = w.size;
         cds[q][slot]   = CD_W'(int'(base_delay[q]) + int'(w.size) / BYTES_PER_TICK);
         count[q]++;
         return 1'b1;
      endfunction

      function void take_head(int q, inout rsp_word_type r);
         r.out_valid = 1'b1;
         r.out_tag   = tags[q][head[q]];
         r.out_size  = sizes[q][head[q]];
         head[q]     = (head[q] + 1) % QUEUE_DEPTH;
         count[q]--;
      endfunction

      function rsp_word_type advance_port(req_word_type w);
         rsp_word_type r;
         int slot;
         r        = '0;
         r.status = STAT_OK;
         case (w.kind)
            REQ_PUSH_IN, REQ_PUSH_OUT: begin
               if (!push_entry(w.kind == REQ_PUSH_IN ? Q_IN : Q_OUT, w)) r.status = STAT_FULL;
            end
            REQ_TICK: begin
               if (head_due(Q_OUT)) begin
                  if (connected) begin
                     take_head(Q_OUT, r);
                     r.out_dest = DEST_REMOTE;
                  end else begin
                     r.status = STAT_NOT_CONNECTED;
                  end
               end
               for (int q = 0; q < 2; q++) begin
                  for (int i = 0; i < count[q]; i++) begin
                     slot = (head[q] + i) % QUEUE_DEPTH;
                     if (cds[q][slot] != '0) cds[q][slot]--;
                  end
               end
            end
            default: begin
               if (head_due(Q_IN)) begin
                  take_head(Q_IN, r);
                  r.out_dest = DEST_LOCAL;
               end else begin
                  r.status = STAT_NONE_READY;
               end
            end
         endcase
         r.incoming_ready = head_due(Q_IN);
         r.outgoing_count = OUT_COUNT_W'(count[Q_OUT]);
         return r;
      endfunction

      function void note_request(req_word_type w);
         rsp_word_type r;
         r = advance_port(w);
         words_in++;
         if (r.status == STAT_FULL) drops++;
         if (r.status == STAT_NOT_CONNECTED) held_sends++;
         if (r.out_valid && r.out_dest == DEST_REMOTE) sends++;
         if (r.out_valid && r.out_dest == DEST_LOCAL) pops++;
         expected_rsps.push_back(r);
      endfunction

      function int pending();
         return expected_rsps.size();
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= REPORT_CAP) $display("MISMATCH at %0t: %s", $time, msg);
      endtask

      task compare_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report($sformatf("response word %0d %s: got %0h, want %0h",
                             words_out, name, got, want));
      endtask

      task check_response(rsp_word_type got);
         rsp_word_type want;
         words_out++;
         if (expected_rsps.size() == 0) begin
            report($sformatf("response word %0d arrived with none outstanding", words_out));
            return;
         end
         want = expected_rsps[0];
         expected_rsps.delete(0);
         compare_field("status", got.status, want.status);
         compare_field("out_valid", got.out_valid, want.out_valid);
         compare_field("out_dest", got.out_dest, want.out_dest);
         compare_field("out_tag", got.out_tag, want.out_tag);
         compare_field("out_size", got.out_size, want.out_size);
         compare_field("incoming_ready", got.incoming_ready, want.incoming_ready);
         compare_field("outgoing_count", got.outgoing_count, want.outgoing_count);
      endtask
   endclass

endpackage

### tb/tb.sv
`timescale 1ns / 1ps
// Testbench top for link_port_delay_queues: directed and random request words
// under several register settings, each response word checked in order.
// Depends on lpdq_pkg, the lpdq channel interfaces and lpdq_tb_pkg.
module tb;
   import lpdq_pkg::*;
   import lpdq_tb_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int IDLE_PCT     = 13;
   localparam int DRAIN_CYCLES = 10;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   logic clock;
   logic reset;
   bit   idling_on;
   int   quiet_cycles = 0;
   int   settings;
   delay_queue_scoreboard sb;

   lpdq_req_if req_if ();
   lpdq_rsp_if rsp_if ();
   lpdq_csr_if csr_if ();

   link_port_delay_queues uut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .csr_port (csr_if)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_if.ready = !idling_on || $urandom_range(99) >= IDLE_PCT;
      end
   end

   always @(posedge clock) begin : monitor
      req_word_type w;
      rsp_word_type r;
      bit moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            w.kind = req_kind_type'(req_if.req_type);
            w.tag  = req_if.msg_tag;
            w.size = req_if.msg_size;
            sb.note_request(w);
            moved = 1'b1;
         end
         if (csr_if.valid && csr_if.ready) begin
            sb.write_reg(csr_if.index, csr_if.data);
            moved = 1'b1;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            r.status         = status_type'(rsp_if.status);
            r.out_valid      = rsp_if.out_valid;
            r.out_dest       = rsp_if.out_dest;
            r.out_tag        = rsp_if.out_tag;
            r.out_size       = rsp_if.out_size;
            r.incoming_ready = rsp_if.incoming_ready;
            r.outgoing_count = rsp_if.outgoing_count;
            sb.check_response(r);
            moved = 1'b1;
         end
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= STALL_LIMIT);
      $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic send_request(req_kind_type kind, logic [TAG_W-1:0] tag,
                               logic [SIZE_W-1:0] size);
      @(negedge clock);
      while (idling_on && $urandom_range(99) < IDLE_PCT) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid    = 1'b1;
      req_if.req_type = kind;
      req_if.msg_tag  = tag;
      req_if.msg_size = size;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic drain();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_if.valid = 1'b1;
      csr_if.index = idx;
      csr_if.data  = data;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   task automatic set_port(logic [BASE_W-1:0] in_base, logic [BASE_W-1:0] out_base,
                           logic conn);
      drain();
      write_reg(CSR_IN_BASE, in_base);
      write_reg(CSR_OUT_BASE, out_base);
      write_reg(CSR_CONNECTED, CSR_DATA_W'(conn));
      settings++;
   endtask

   function automatic logic [SIZE_W-1:0] pick_size();
      int roll;
      roll = $urandom_range(99);
      if (roll < 80) return SIZE_W'($urandom_range(999));
      if (roll < 90) return SIZE_W'($urandom);
      case ($urandom_range(3))
         0:       return '0;
         1:       return '1;
         2:       return SIZE_W'(99);
         default: return SIZE_W'(100);
      endcase
   endfunction

   task automatic random_phase(int items, int tick_pct);
      req_kind_type kind;
      repeat (items) begin
         if ($urandom_range(99) < tick_pct) begin
            kind = REQ_TICK;
         end else begin
            case ($urandom_range(2))
               0:       kind = REQ_PUSH_IN;
               1:       kind = REQ_PUSH_OUT;
               default: kind = REQ_POP_IN;
            endcase
         end
         send_request(kind, TAG_W'($urandom), pick_size());
      end
   endtask

   initial begin
      sb              = new();
      reset           = 1'b1;
      idling_on       = 1'b1;
      settings        = 1;
      req_if.valid    = 1'b0;
      req_if.req_type = REQ_PUSH_IN;
      req_if.msg_tag  = '0;
      req_if.msg_size = '0;
      csr_if.valid    = 1'b0;
      csr_if.index    = CSR_IN_BASE;
      csr_if.data     = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: delays of 3, remote detached
      send_request(REQ_POP_IN,   16'h0000, 16'h0000);
      send_request(REQ_TICK,     16'h0000, 16'h0000);
      send_request(REQ_PUSH_IN,  16'h0000, 16'h0000);
      send_request(REQ_PUSH_IN,  16'hffff, 16'hffff);
      send_request(REQ_PUSH_OUT, 16'h1234, 16'd99);
      send_request(REQ_POP_IN,   16'h0000, 16'h0000);
      repeat (3) send_request(REQ_TICK, 16'h0000, 16'h0000);
      send_request(REQ_TICK,     16'h0000, 16'h0000);
      send_request(REQ_POP_IN,   16'h0000, 16'h0000);
      send_request(REQ_POP_IN,   16'h0000, 16'h0000);

      set_port(8'd0, 8'd255, 1'b1);
      send_request(REQ_TICK,     16'h0000, 16'h0000);
      send_request(REQ_PUSH_OUT, 16'hffff, 16'h0000);
      send_request(REQ_PUSH_IN,  16'h5a5a, 16'd100);
      // fill the incoming queue, last word dropped
      repeat (QUEUE_DEPTH - 1) send_request(REQ_PUSH_IN, TAG_W'($urandom), pick_size());

      set_port(8'd0, 8'd0, 1'b1);
      idling_on = 1'b0;
      random_phase(200, 30);

      set_port(8'd5, 8'd2, 1'b0);
      idling_on = 1'b1;
      random_phase(130, 30);

      set_port(8'd255, 8'd255, 1'b1);
      write_reg(CSR_SPARE, '1);
      random_phase(130, 75);

      repeat (3) begin
         set_port(BASE_W'($urandom_range(0, 12)), BASE_W'($urandom), 1'($urandom));
         random_phase(160, $urandom_range(20, 50));
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d request words over %0d register settings: %0d local pops,",
               sb.words_in, settings, sb.pops);
      $display("%0d remote sends, %0d held while detached, %0d dropped pushes, %0d mismatches",
               sb.sends, sb.held_sends, sb.drops, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
